@@ rtl/sqd_pkg.sv @@
// ----------------------------------------------------------------------------
// sqd_pkg
// Types and constants shared by the shortest queue dispatcher modules.
// ----------------------------------------------------------------------------
package sqd_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_SERVERS_DEF = 3;

	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	typedef enum logic [1:0] {
		KIND_PLACED   = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_REPORT   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SRV_STARTED    = 2'd0,
		SRV_CONTINUING = 2'd1,
		SRV_IDLE       = 2'd2
	} srv_state_t;

	typedef struct packed {
		logic [7:0]  len;
		logic [15:0] id;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  unit_index;
		srv_state_t  server_state;
		logic [15:0] served_id;
		logic [31:0] finish_time;
		logic        all_idle;
		logic        last;
	} result_t;

endpackage

@@ rtl/sqd_queue.sv @@
// ----------------------------------------------------------------------------
// sqd_queue
// Per-server job FIFO: circular buffer memory with a registered head read.
// ----------------------------------------------------------------------------
module sqd_queue #(
	parameter int DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sqd_pkg::queue_ctl_t        ctl,
	input  sqd_pkg::entry_t            wr_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output sqd_pkg::entry_t            head_data
);
	import sqd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem [DEPTH];
	entry_t             rd_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W:0]     wr_sum;
	logic [PTR_W-1:0]   wr_ptr;
	logic [PTR_W-1:0]   head_next;

	always_comb begin
		wr_sum = (PTR_W+1)'(head_q) + (PTR_W+1)'(count_q);
		if (wr_sum >= (PTR_W+1)'(DEPTH)) begin
			wr_ptr = PTR_W'(wr_sum - (PTR_W+1)'(DEPTH));
		end else begin
			wr_ptr = PTR_W'(wr_sum);
		end
		if (head_q == PTR_W'(DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_next;
			end
		end
	end

	// A write into the head slot (empty queue) is forwarded to the read register.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr] <= wr_data;
		end
		if (ctl.push && (wr_ptr == head_q)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[head_q];
		end
	end

	assign count     = count_q;
	assign head_data = rd_q;

endmodule

@@ rtl/sqd_result_reg.sv @@
// ----------------------------------------------------------------------------
// sqd_result_reg
// Output register of the result channel with valid and ready.
// ----------------------------------------------------------------------------
module sqd_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sqd_pkg::result_t  d,
	input  logic              ready,
	output logic              valid,
	output sqd_pkg::result_t  q,
	output logic              free
);
	import sqd_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

@@ rtl/shortest_queue_dispatcher_core.sv @@
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_core
// Join-shortest-queue dispatcher feeding NUM_SERVERS servers.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid/item_ready) takes commands: an arrival places
// job_id and service_len in the least loaded queue, or is rejected if that
// queue is full; a tick serves every server once and then advances time by one.
// The result channel (result_valid/result_ready) gives one result for an
// arrival and NUM_SERVERS reports for a tick, in server order; last marks
// the final result of each item.
// An accepted item is held in an input register; one result is formed per
// cycle from it while the output register is free, and loaded into that
// register, which drives result_valid. Arrivals sustain one per cycle while
// the output register is free; a tick forms its reports in turn through the
// single output register; no new item is taken until its last report is loaded.
// When the receiver stalls, the output register holds its result and the
// input register holds the item, and item_ready drops.
// Reset empties all queues, marks all servers idle and sets time to zero.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_core #(
	parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_SERVERS = sqd_pkg::NUM_SERVERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        cmd,
	input  logic [15:0] job_id,
	input  logic [7:0]  service_len,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [1:0]  unit_index,
	output logic [1:0]  server_state,
	output logic [15:0] served_id,
	output logic [31:0] finish_time,
	output logic        all_idle,
	output logic        last
);
	import sqd_pkg::*;

	localparam int IDX_W  = $clog2(NUM_SERVERS);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int LOAD_W = $clog2(QUEUE_DEPTH + 2);

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [15:0]            job_id_s1;
	logic [7:0]             service_len_s1;
	logic [IDX_W-1:0]       idx_q;
	logic                   idle_q;

	logic [NUM_SERVERS-1:0] busy_q;
	logic [15:0]            job_q [NUM_SERVERS];
	logic [31:0]            end_q [NUM_SERVERS];
	logic [31:0]            now_q;

	logic [CNT_W-1:0]       count [NUM_SERVERS];
	entry_t                 head [NUM_SERVERS];
	queue_ctl_t             qctl [NUM_SERVERS];
	entry_t                 wr_entry;

	logic [IDX_W-1:0]       pick;
	logic                   full;
	logic                   serve;
	logic                   has_job;
	logic [31:0]            start_end;
	logic                   idle_now;
	logic                   is_tick;
	logic                   step_fire;
	logic                   step_last;
	logic                   out_free;
	logic                   item_fire;
	result_t                res_d;
	result_t                res_q;

	assign is_tick   = (cmd_s1 == CMD_TICK);
	assign step_fire = valid_s1 && out_free;
	assign step_last = step_fire && (!is_tick || (idx_q == IDX_W'(NUM_SERVERS - 1)));
	assign item_ready = !valid_s1 || step_last;
	assign item_fire  = item_valid && item_ready;
	assign wr_entry   = '{len: service_len_s1, id: job_id_s1};

	always_comb begin
		logic [LOAD_W-1:0] best_load;
		logic [LOAD_W-1:0] cur_load;
		pick      = '0;
		best_load = LOAD_W'(count[0]) + LOAD_W'(busy_q[0]);
		for (int i = 1; i < NUM_SERVERS; i++) begin
			cur_load = LOAD_W'(count[i]) + LOAD_W'(busy_q[i]);
			if (cur_load < best_load) begin
				best_load = cur_load;
				pick      = IDX_W'(i);
			end
		end
		full = (count[pick] == CNT_W'(QUEUE_DEPTH));
	end

	// A server ends the tick idle only if it may serve now and has nothing queued.
	always_comb begin
		idle_now = 1'b1;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			if ((busy_q[i] && (end_q[i] != now_q)) || (count[i] != '0)) begin
				idle_now = 1'b0;
			end
		end
	end

	always_comb begin
		serve     = !busy_q[idx_q] || (end_q[idx_q] == now_q);
		has_job   = (count[idx_q] != '0);
		start_end = now_q + 32'(head[idx_q].len);
	end

	always_comb begin
		for (int i = 0; i < NUM_SERVERS; i++) begin
			qctl[i].push = step_fire && !is_tick && (pick == IDX_W'(i)) && !full;
			qctl[i].pop  = step_fire && is_tick && (idx_q == IDX_W'(i)) && serve && has_job;
		end
	end

	always_comb begin
		res_d = '0;
		if (!is_tick) begin
			res_d.kind         = full ? KIND_REJECTED : KIND_PLACED;
			res_d.unit_index   = 2'(pick);
			res_d.server_state = SRV_STARTED;
			res_d.served_id    = job_id_s1;
			res_d.last         = 1'b1;
		end else begin
			res_d.kind       = KIND_REPORT;
			res_d.unit_index = 2'(idx_q);
			res_d.all_idle   = (idx_q == '0) ? idle_now : idle_q;
			res_d.last       = (idx_q == IDX_W'(NUM_SERVERS - 1));
			if (!serve) begin
				res_d.server_state = SRV_CONTINUING;
				res_d.served_id    = job_q[idx_q];
				res_d.finish_time  = end_q[idx_q];
			end else if (has_job) begin
				res_d.server_state = SRV_STARTED;
				res_d.served_id    = head[idx_q].id;
				res_d.finish_time  = start_end;
			end else begin
				res_d.server_state = SRV_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (step_last) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (step_fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			cmd_s1         <= cmd;
			job_id_s1      <= job_id;
			service_len_s1 <= service_len;
		end
		if (step_fire && is_tick && (idx_q == '0)) begin
			idle_q <= idle_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			now_q  <= '0;
		end else if (step_fire && is_tick) begin
			if (serve) begin
				busy_q[idx_q] <= has_job;
			end
			if (step_last) begin
				now_q <= now_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && is_tick && serve && has_job) begin
			job_q[idx_q] <= head[idx_q].id;
			end_q[idx_q] <= start_end;
		end
	end

	for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_queue
		sqd_queue #(
			.DEPTH(QUEUE_DEPTH)
		) u_queue (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (qctl[g]),
			.wr_data  (wr_entry),
			.count    (count[g]),
			.head_data(head[g])
		);
	end

	sqd_result_reg u_result_reg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (step_fire),
		.d     (res_d),
		.ready (result_ready),
		.valid (result_valid),
		.q     (res_q),
		.free  (out_free)
	);

	assign kind         = res_q.kind;
	assign unit_index   = res_q.unit_index;
	assign server_state = res_q.server_state;
	assign served_id    = res_q.served_id;
	assign finish_time  = res_q.finish_time;
	assign all_idle     = res_q.all_idle;
	assign last         = res_q.last;

endmodule

@@ rtl/sqd_checker.sv @@
// ----------------------------------------------------------------------------
// sqd_checker
// Port-level checks of the dispatcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sqd_checker #(
	parameter int NUM_SERVERS = sqd_pkg::NUM_SERVERS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        cmd,
	input logic [15:0] job_id,
	input logic [7:0]  service_len,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  kind,
	input logic [1:0]  unit_index,
	input logic [1:0]  server_state,
	input logic [15:0] served_id,
	input logic [31:0] finish_time,
	input logic        all_idle,
	input logic        last
);
	import sqd_pkg::*;

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(cmd)
			&& $stable(job_id) && $stable(service_len))
		else $error("Waiting item changed.");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(served_id)
			&& $stable(kind) && $stable(unit_index) && $stable(finish_time))
		else $error("Stalled result changed.");

	a_arrival_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind != KIND_REPORT) |-> last && !all_idle
			&& (finish_time == '0) && (server_state == SRV_STARTED))
		else $error("Arrival result is malformed.");

	a_last_report: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_REPORT) && last |->
			(unit_index == 2'(NUM_SERVERS - 1)))
		else $error("Final report is not from the last server.");

	a_idle_report: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_REPORT) && (server_state == SRV_IDLE) |->
			(served_id == '0) && (finish_time == '0))
		else $error("Idle report carries a job.");

endmodule

bind shortest_queue_dispatcher_core sqd_checker #(
	.NUM_SERVERS(NUM_SERVERS)
) u_sqd_checker (.*);
